>>> rtl/lbse_pkg.sv
package lbse_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int NUM_LEDS  = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_ON    = 3'd3,
        OP_OFF   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_MOD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] start;
        logic [15:0] period;
        logic [15:0] duration;
    } slot_entry_t;

endpackage

>>> rtl/led_blink_slot_engine.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  opcode, led_index, period_ms, duration_ms
// out      output     out_valid / out_stall led_levels, blinking_mask, start_accepted
//
// One transaction is handled at a time. Start, stop, on, off and unused codes go
// straight from idle to the finish state. A tick walks every slot in turn: a free
// slot is skipped, a slot in use is read from the table, an expired one is freed and
// the others run the remainder unit, two bits per step, until its done flag is seen.
// Reset frees all slots, turns all LEDs off and zeroes the millisecond counter.
// A finished result waits in the output register while out_stall is high.
module led_blink_slot_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [2:0]  led_index,
    input  logic [15:0] period_ms,
    input  logic [15:0] duration_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  led_levels,
    output logic [7:0]  blinking_mask,
    output logic        start_accepted
);

    localparam int SW = lbse_pkg::SLOT_W;
    localparam int NS = lbse_pkg::NUM_SLOTS;

    lbse_pkg::state_t state_reg;
    lbse_pkg::state_t state_next;

    logic [SW-1:0]   slot_reg;
    logic [SW-1:0]   slot_next;
    logic [31:0]     now_reg;
    logic [31:0]     now_next;
    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   valid_next;
    logic [7:0]      level_reg;
    logic [7:0]      level_next;
    logic            accepted_reg;
    logic            accepted_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_levels_reg;
    logic [7:0]      out_blink_reg;
    logic            out_accepted_reg;
    logic [2:0]      slot_led_reg [NS];

    lbse_pkg::slot_entry_t mem [NS];
    lbse_pkg::slot_entry_t wr_data;
    lbse_pkg::slot_entry_t rd_data_reg;
    logic                  wr_en;
    logic [SW-1:0]         wr_addr;
    logic                  rd_en;

    lbse_pkg::op_t op;
    logic          led_ok;
    logic          free_found;
    logic [SW-1:0] free_slot;
    logic [7:0]    blink_mask;
    logic          last_slot;
    logic [31:0]   elapsed;
    logic          expired;
    logic          load_out;
    logic          out_free;
    logic          mod_start;
    logic          mod_done;
    logic [15:0]   mod_rem;
    logic [2:0]    cur_led;

    assign op        = lbse_pkg::op_t'(opcode);
    assign led_ok    = 32'(led_index) < lbse_pkg::NUM_LEDS;
    assign last_slot = (slot_reg == SW'(NS - 1));
    assign cur_led   = slot_led_reg[slot_reg];
    assign elapsed   = now_reg - rd_data_reg.start;
    assign expired   = (rd_data_reg.duration != 16'd0) && (elapsed > {16'd0, rd_data_reg.duration});
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != lbse_pkg::ST_IDLE);

    // Lowest free slot wins.
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_found = 1'b1;
                free_slot  = SW'(s);
            end
        end
    end

    always_comb
    begin
        blink_mask = '0;
        for (int s = 0; s < NS; s++)
        begin
            if (valid_reg[s])
            begin
                blink_mask[slot_led_reg[s]] = 1'b1;
            end
        end
    end

    assign wr_addr          = free_slot;
    assign wr_data.start    = now_reg;
    assign wr_data.period   = (period_ms == 16'd0) ? 16'd1 : period_ms;
    assign wr_data.duration = duration_ms;

    lbse_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (elapsed),
        .divisor   (rd_data_reg.period),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbse_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op == lbse_pkg::OP_TICK) ? lbse_pkg::ST_SCAN
                                                           : lbse_pkg::ST_FINISH;
                end
            end
            lbse_pkg::ST_SCAN:
            begin
                if (valid_reg[slot_reg])
                begin
                    state_next = lbse_pkg::ST_LOAD;
                end
                else if (last_slot)
                begin
                    state_next = lbse_pkg::ST_FINISH;
                end
            end
            lbse_pkg::ST_LOAD:
            begin
                if (!expired)
                begin
                    state_next = lbse_pkg::ST_MOD;
                end
                else
                begin
                    state_next = last_slot ? lbse_pkg::ST_FINISH : lbse_pkg::ST_SCAN;
                end
            end
            lbse_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = last_slot ? lbse_pkg::ST_FINISH : lbse_pkg::ST_SCAN;
                end
            end
            lbse_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lbse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        slot_next     = slot_reg;
        now_next      = now_reg;
        valid_next    = valid_reg;
        level_next    = level_reg;
        accepted_next = accepted_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        mod_start     = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            lbse_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    accepted_next = 1'b0;
                    slot_next     = '0;
                    case (op)
                        lbse_pkg::OP_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                        end
                        lbse_pkg::OP_START:
                        begin
                            if (led_ok && free_found)
                            begin
                                valid_next[free_slot] = 1'b1;
                                wr_en                 = 1'b1;
                                accepted_next         = 1'b1;
                            end
                        end
                        lbse_pkg::OP_STOP:
                        begin
                            if (led_ok)
                            begin
                                for (int s = 0; s < NS; s++)
                                begin
                                    if (slot_led_reg[s] == led_index)
                                    begin
                                        valid_next[s] = 1'b0;
                                    end
                                end
                                level_next[led_index] = 1'b0;
                            end
                        end
                        lbse_pkg::OP_ON:
                        begin
                            if (led_ok)
                            begin
                                level_next[led_index] = 1'b1;
                            end
                        end
                        lbse_pkg::OP_OFF:
                        begin
                            if (led_ok)
                            begin
                                level_next[led_index] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lbse_pkg::ST_SCAN:
            begin
                if (valid_reg[slot_reg])
                begin
                    rd_en = 1'b1;
                end
                else if (!last_slot)
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            lbse_pkg::ST_LOAD:
            begin
                if (expired)
                begin
                    valid_next[slot_reg] = 1'b0;
                    level_next[cur_led]  = 1'b0;
                    if (!last_slot)
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
                else
                begin
                    mod_start = 1'b1;
                end
            end
            lbse_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    level_next[cur_led] = (mod_rem > (rd_data_reg.period >> 1));
                    if (!last_slot)
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            lbse_pkg::ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbse_pkg::ST_IDLE;
            slot_reg      <= '0;
            now_reg       <= '0;
            valid_reg     <= '0;
            level_reg     <= '0;
            accepted_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            level_reg     <= level_next;
            accepted_reg  <= accepted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_levels_reg   <= level_reg;
            out_blink_reg    <= blink_mask;
            out_accepted_reg <= accepted_reg;
        end
        if (wr_en)
        begin
            slot_led_reg[wr_addr] <= led_index;
        end
    end

    // Slot table: one write port for start, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_levels     = out_levels_reg;
    assign blinking_mask  = out_blink_reg;
    assign start_accepted = out_accepted_reg;

endmodule

>>> rtl/lbse_mod_unit.sv
module lbse_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = 32 / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      rem_next;
    logic [31:0]      dvd_reg;
    logic [31:0]      dvd_next;
    logic [15:0]      dvs_reg;

    // Restoring remainder, two dividend bits per cycle.
    always_comb
    begin
        logic [16:0] trial;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial    = {rem_next, dvd_next[31]};
            dvd_next = {dvd_next[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
